// ===== src/vhi_pkg.sv =====
// Package with shared types and constants of the voxel hash insert unit.
`default_nettype none
package vhi_pkg;

    localparam int TableDepthLog2Default = 16;
    localparam int VoxelIndexBitsDefault = 20;

    localparam logic [31:0] BASE_MUL = 32'h9E3779B6;
    localparam logic [31:0] STEP_MUL = 32'hB504F333;
    localparam logic [31:0] KEY_SEED = 32'd5381;

    localparam logic [2:0] STATUS_INSERTED  = 3'd0;
    localparam logic [2:0] STATUS_DUPLICATE = 3'd1;
    localparam logic [2:0] STATUS_FULL      = 3'd2;
    localparam logic [2:0] STATUS_OCCUPIED  = 3'd3;
    localparam logic [2:0] STATUS_EMPTY     = 3'd4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [2:0] REG_INV_LEAF  = 3'd3;
    localparam logic [2:0] REG_TABLE_LOG = 3'd4;

    typedef struct packed {
        logic               command;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
        logic [15:0]        read_slot;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] slot_index;
        logic [16:0] probe_count;
        logic [19:0] voxel_x;
        logic [19:0] voxel_y;
        logic [19:0] voxel_z;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [16:0] occupied_count;
    } result_t;

endpackage
`default_nettype wire

// ===== src/voxel_hash_insert_unit.sv =====
// Voxel hash insert unit: quantizer, hash sequencer and open-addressed slot table.
//
//   Channel   Signals                          Handshake
//   item      start, busy, item                transfer when start && !busy
//   result    result_valid, result             one-cycle strobe, no back pressure
//   config    cfg_valid, cfg_ready, cfg_index, transfer when cfg_valid && cfg_ready
//             cfg_data
//
// After reset the unit sweeps the slot table once, one slot per cycle; busy is
// high throughout. Configuration is always ready.
// An insert quantizes each axis and hashes the key on the one shared 32x32
// multiplier, then probes; each probe is a registered memory read, then a compare.
// A read is one such probe of the slot in read_slot. The result strobe is registered
// at the final compare; a new item may transfer in the same cycle as the strobe.
`default_nettype none
module voxel_hash_insert_unit
    import vhi_pkg::*;
#(
    parameter int TABLE_DEPTH_LOG2 = TableDepthLog2Default,
    parameter int VOXEL_INDEX_BITS = VoxelIndexBitsDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire item_t       item,
    output logic             result_valid,
    output result_t          result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int TD = TABLE_DEPTH_LOG2;
    localparam int VB = VOXEL_INDEX_BITS;
    localparam int EW = 1 + 3 * VB + 24;
    localparam int DEPTH = 1 << TD;
    localparam logic [VB-1:0] VOXEL_MAX = {VB{1'b1}};
    localparam logic [4:0] LOG_MIN = 5'd3;
    localparam logic [4:0] LOG_MAX = 5'(TD);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_QMUL, S_QACC, S_HBASE, S_HSTEP, S_HSET, S_RD, S_CHK
    } state_t;

    // Memory entry: valid bit, three voxel indices, three colour bytes.
    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rdata_reg;

    state_t        state_reg;
    logic [TD:0]   clr_reg;
    item_t         item_reg;
    logic [1:0]    axis_reg;
    logic [63:0]   prod_reg;
    logic          nonpos_reg;
    logic [31:0]   key_reg;
    logic [VB-1:0] vox_reg [3];
    logic [TD-1:0] pos_reg;
    logic [TD-1:0] step_reg;
    logic [TD:0]   probe_reg;
    logic [TD:0]   entry_reg;
    logic [4:0]    lg_eff_reg;
    logic          result_valid_reg;
    result_t       result_reg;

    logic signed [31:0] origin_reg [3];
    logic [31:0]        inv_leaf_reg;
    logic [4:0]         table_log_reg;

    // Effective table size, clamped between 8 slots and the implemented depth.
    logic [4:0]    lg_eff;
    logic [TD-1:0] mask;
    logic [TD:0]   size;
    always_comb
    begin
        if (table_log_reg < LOG_MIN)
            lg_eff = LOG_MIN;
        else if (table_log_reg > LOG_MAX)
            lg_eff = LOG_MAX;
        else
            lg_eff = table_log_reg;
    end
    assign mask = ~({TD{1'b1}} << lg_eff_reg);
    assign size = (TD+1)'(1) << lg_eff_reg;

    // Quantizer difference for the current axis, exact in 33 bits.
    logic signed [31:0] point_sel;
    logic signed [32:0] diff;
    always_comb
    begin
        case (axis_reg)
            2'd0:    point_sel = item_reg.point_x;
            2'd1:    point_sel = item_reg.point_y;
            default: point_sel = item_reg.point_z;
        endcase
        diff = 33'(point_sel) - 33'(origin_reg[axis_reg]);
    end

    // Key magnitude: two's complement when the top bit is set.
    logic [31:0] key_abs;
    assign key_abs = key_reg[31] ? (32'd0 - key_reg) : key_reg;

    // The one shared multiplier.
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    always_comb
    begin
        case (state_reg)
            S_QMUL:
            begin
                mul_a = diff[31:0];
                mul_b = inv_leaf_reg;
            end
            S_HBASE:
            begin
                mul_a = key_abs;
                mul_b = BASE_MUL;
            end
            default:
            begin
                mul_a = key_abs;
                mul_b = STEP_MUL;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    logic [VB-1:0] q_sat;
    always_comb
    begin
        if (nonpos_reg)
            q_sat = '0;
        else if (prod_reg[63:32] > 32'(VOXEL_MAX))
            q_sat = VOXEL_MAX;
        else
            q_sat = prod_reg[VB+31:32];
    end

    logic [5:0]  hash_shift;
    logic [31:0] hash_slot;
    assign hash_shift = 6'd32 - {1'b0, lg_eff_reg};
    assign hash_slot  = prod_reg[31:0] >> hash_shift;

    // Stored entry fields.
    logic          st_valid;
    logic [VB-1:0] st_vox [3];
    logic [23:0]   st_col;
    assign st_valid  = rdata_reg[EW-1];
    assign st_vox[0] = rdata_reg[24+3*VB-1:24+2*VB];
    assign st_vox[1] = rdata_reg[24+2*VB-1:24+VB];
    assign st_vox[2] = rdata_reg[24+VB-1:24];
    assign st_col    = rdata_reg[23:0];

    logic          vox_match;
    logic [TD:0]   probe_next;
    logic [TD-1:0] pos_next;
    logic [23:0]   in_col;
    assign vox_match  = (st_vox[0] == vox_reg[0]) && (st_vox[1] == vox_reg[1]) &&
                        (st_vox[2] == vox_reg[2]);
    assign probe_next = probe_reg + (TD+1)'(1);
    assign pos_next   = (pos_reg + step_reg) & mask;
    assign in_col     = {item_reg.red_in, item_reg.green_in, item_reg.blue_in};

    // Memory port: one write (clear sweep or insert), one registered read.
    logic          mem_we;
    logic [TD-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = {1'b1, vox_reg[0], vox_reg[1], vox_reg[2], in_col};
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg[TD-1:0];
            mem_wdata = '0;
        end
        else if (state_reg == S_CHK && item_reg.command == CMD_INSERT && !st_valid)
            mem_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (state_reg == S_RD)
            rdata_reg <= mem[pos_reg];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            inv_leaf_reg  <= 32'd6553600;
            table_log_reg <= 5'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:  origin_reg[0] <= cfg_data;
                REG_ORIGIN_Y:  origin_reg[1] <= cfg_data;
                REG_ORIGIN_Z:  origin_reg[2] <= cfg_data;
                REG_INV_LEAF:  inv_leaf_reg  <= cfg_data;
                REG_TABLE_LOG: table_log_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    function automatic logic [19:0] vox_out(input logic [VB-1:0] v);
        return 20'(v);
    endfunction

    // Sequencer with registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            entry_reg        <= '0;
            result_valid_reg <= 1'b0;
            axis_reg         <= '0;
            probe_reg        <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + (TD+1)'(1);
                    if (clr_reg == (TD+1)'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        item_reg   <= item;
                        lg_eff_reg <= lg_eff;
                        axis_reg   <= '0;
                        key_reg    <= KEY_SEED;
                        probe_reg  <= '0;
                        pos_reg    <= TD'(item.read_slot) & ~({TD{1'b1}} << lg_eff);
                        state_reg  <= (item.command == CMD_READ) ? S_RD : S_QMUL;
                    end
                end
                S_QMUL:
                begin
                    prod_reg   <= mul_p;
                    nonpos_reg <= diff[32] || (diff == '0);
                    state_reg  <= S_QACC;
                end
                S_QACC:
                begin
                    vox_reg[axis_reg] <= q_sat;
                    key_reg  <= (key_reg << 5) + key_reg + 32'(q_sat);
                    axis_reg <= axis_reg + 2'd1;
                    state_reg <= (axis_reg == 2'd2) ? S_HBASE : S_QMUL;
                end
                S_HBASE:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_HSTEP;
                end
                S_HSTEP:
                begin
                    pos_reg   <= hash_slot[TD-1:0];
                    prod_reg  <= mul_p;
                    state_reg <= S_HSET;
                end
                S_HSET:
                begin
                    step_reg  <= hash_slot[TD-1:0] | TD'(1);
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    result_reg.occupied_count <= 17'(entry_reg);
                    result_reg.slot_index     <= 16'(pos_reg);
                    result_reg.voxel_x        <= vox_out(vox_reg[0]);
                    result_reg.voxel_y        <= vox_out(vox_reg[1]);
                    result_reg.voxel_z        <= vox_out(vox_reg[2]);
                    {result_reg.red_out, result_reg.green_out, result_reg.blue_out}
                        <= in_col;
                    result_reg.probe_count    <= 17'(probe_next);
                    if (item_reg.command == CMD_READ)
                    begin
                        result_reg.probe_count <= '0;
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                        if (st_valid)
                        begin
                            result_reg.status  <= STATUS_OCCUPIED;
                            result_reg.voxel_x <= vox_out(st_vox[0]);
                            result_reg.voxel_y <= vox_out(st_vox[1]);
                            result_reg.voxel_z <= vox_out(st_vox[2]);
                            {result_reg.red_out, result_reg.green_out, result_reg.blue_out}
                                <= st_col;
                        end
                        else
                        begin
                            result_reg.status  <= STATUS_EMPTY;
                            result_reg.voxel_x <= '0;
                            result_reg.voxel_y <= '0;
                            result_reg.voxel_z <= '0;
                            {result_reg.red_out, result_reg.green_out, result_reg.blue_out}
                                <= '0;
                        end
                    end
                    else if (!st_valid)
                    begin
                        entry_reg                 <= entry_reg + (TD+1)'(1);
                        result_reg.occupied_count <= 17'(entry_reg + (TD+1)'(1));
                        result_reg.status         <= STATUS_INSERTED;
                        result_valid_reg          <= 1'b1;
                        state_reg                 <= S_IDLE;
                    end
                    else if (vox_match)
                    begin
                        result_reg.status <= STATUS_DUPLICATE;
                        {result_reg.red_out, result_reg.green_out, result_reg.blue_out}
                            <= st_col;
                        result_valid_reg  <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                    else if (probe_next == size)
                    begin
                        result_reg.status      <= STATUS_FULL;
                        result_reg.slot_index  <= '0;
                        result_valid_reg       <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                    else
                    begin
                        probe_reg <= probe_next;
                        pos_reg   <= pos_next;
                        state_reg <= S_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while busy");
    a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_reg <= (TD+1)'(DEPTH))
        else $error("entry count above table depth");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> (probe_reg < size))
        else $error("probe count reached table size");
`endif

endmodule
`default_nettype wire
